[rtl/lcc_pkg.sv]
// Package for the linear convolution and correlation block.
// Holds the request, response and pipeline control types, field widths and operation codes.
// Depends on nothing; lcc_mac, the top module and the testbench import it (lcc_ram does not).
package lcc_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int PROD_BITS      = 2 * SAMPLE_BITS;
   localparam int PLEN_BITS      = 11;
   localparam int ACC_BITS       = PROD_BITS + PLEN_BITS;
   localparam int RESULT_BITS    = 48;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_TAIL   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLEN = 2'd1;

   typedef struct packed {
      logic [1:0]                    operation;
      logic signed [SAMPLE_BITS-1:0] sample_value;
   } lcc_req_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] result_value;
      logic                          last_of_stream;
   } lcc_rsp_type;

   typedef struct packed {
      logic valid;
      logic first_tap;
      logic last_tap;
      logic live;
   } lcc_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } lcc_state_type;

endpackage

[rtl/lcc_ram.sv]
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the patch taps and the sample history; depends on nothing.
module lcc_ram #(
   parameter int DEPTH = 1024,
   parameter int DATA_BITS = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/lcc_mac.sv]
// Multiply-accumulate pipeline: one registered product stage and one accumulator stage.
// Depends on lcc_pkg for the control struct and the widths.
module lcc_mac
   import lcc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  lcc_ctl_type                   ctl,
   input  logic signed [SAMPLE_BITS-1:0] patch_tap,
   input  logic signed [SAMPLE_BITS-1:0] hist_sample,
   output logic signed [ACC_BITS-1:0]    acc_sum,
   output logic                          done
);

   logic signed [SAMPLE_BITS-1:0] hist_gated;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   lcc_ctl_type                   pctl_ff, pctl_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic                          done_ff, done_in;

   always_comb begin
      hist_gated = ctl.live ? hist_sample : '0;
      prod_in    = PROD_BITS'(patch_tap) * PROD_BITS'(hist_gated);
      pctl_in    = ctl;
      acc_in     = acc_ff;
      if (pctl_ff.valid) begin
         if (pctl_ff.first_tap) begin
            acc_in = ACC_BITS'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_BITS'(prod_ff);
         end
      end
      done_in = pctl_ff.valid && pctl_ff.last_tap;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         pctl_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         pctl_ff <= pctl_in;
         done_ff <= done_in;
      end
   end

   assign acc_sum = acc_ff;
   assign done    = done_ff;

endmodule

[rtl/linear_convolution_correlation.sv]
// A sample or tail request runs its P taps through the run, drain and finish states, and its
// response is registered once the output slot is free; taps go one per cycle through the patch
// and history read ports. Requests stall until idle, where loads take one request per cycle.
// Reset is synchronous; it sets the controller, history fill count and CSRs, not data registers.
// The history reads as zero through the fill count, so no clearing pass runs after reset.
module linear_convolution_correlation
   import lcc_pkg::*;
#(
   parameter int MAX_TAPS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lcc_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lcc_rsp_type               rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PLEN_BITS-1:0]      csr_wdata
);

   localparam int AW = $clog2(MAX_TAPS);
   localparam int FW = $clog2(MAX_TAPS + 1);

   lcc_state_type        state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [PLEN_BITS-1:0] plen_ff, plen_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [PLEN_BITS-1:0] taps_ff, taps_in;
   logic [PLEN_BITS-1:0] tail_ff, tail_in;
   logic                 last_ff, last_in;
   logic [AW-1:0]        k_ff, k_in;
   lcc_ctl_type          ctl_ff, ctl_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lcc_rsp_type          rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 is_push;
   logic [PLEN_BITS-1:0] taps_p;
   logic [PLEN_BITS-1:0] pm1;
   logic [AW-1:0]        pm1_aw;
   logic [PLEN_BITS-1:0] tap_idx;
   logic [AW-1:0]        ptr_next;
   logic [FW-1:0]        fill_next;
   logic [AW-1:0]        age;
   logic [AW-1:0]        hist_rd_addr;
   logic                 patch_wr_en;
   logic                 hist_wr_en;
   logic [SAMPLE_BITS-1:0] hist_wr_data;
   logic [SAMPLE_BITS-1:0] patch_rd;
   logic [SAMPLE_BITS-1:0] hist_rd;
   logic signed [ACC_BITS-1:0] acc_sum;
   logic                 mac_done;
   logic                 slot_free;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_push   = (req_data.operation == OP_SAMPLE) || (req_data.operation == OP_TAIL);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (plen_ff == '0) begin
         taps_p = PLEN_BITS'(1);
      end else if (32'(plen_ff) > 32'(MAX_TAPS)) begin
         taps_p = PLEN_BITS'(MAX_TAPS);
      end else begin
         taps_p = plen_ff;
      end
      pm1       = taps_p - 1'b1;
      pm1_aw    = AW'(pm1);
      tap_idx   = (taps_ff >= taps_p) ? '0 : taps_ff;
      ptr_next  = (ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
      fill_next = (fill_ff == FW'(MAX_TAPS)) ? fill_ff : fill_ff + 1'b1;
      age       = mode_ff ? (pm1_aw - k_ff) : k_ff;
      if (ptr_ff >= age) begin
         hist_rd_addr = ptr_ff - age;
      end else begin
         hist_rd_addr = ptr_ff + AW'(MAX_TAPS) - age;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      plen_in = plen_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MODE) begin
            mode_in = csr_wdata[0];
         end else if (csr_index == CSR_PLEN) begin
            plen_in = csr_wdata;
         end
      end

      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      taps_in      = taps_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      patch_wr_en  = 1'b0;
      hist_wr_en   = 1'b0;
      hist_wr_data = '0;
      if (accept) begin
         unique case (req_data.operation)
            OP_LOAD: begin
               patch_wr_en = 1'b1;
               taps_in     = tap_idx + 1'b1;
               ptr_in      = '0;
               fill_in     = '0;
               tail_in     = '0;
            end
            OP_SAMPLE: begin
               hist_wr_en   = 1'b1;
               hist_wr_data = req_data.sample_value;
               ptr_in       = ptr_next;
               fill_in      = fill_next;
               tail_in      = '0;
               last_in      = 1'b0;
            end
            OP_TAIL: begin
               hist_wr_en = 1'b1;
               ptr_in     = ptr_next;
               fill_in    = fill_next;
               tail_in    = (tail_ff == '1) ? tail_ff : tail_ff + 1'b1;
               last_in    = (tail_in == pm1);
            end
            default: begin
            end
         endcase
      end

      ctl_in.valid     = (state_ff == ST_RUN);
      ctl_in.first_tap = (k_ff == '0);
      ctl_in.last_tap  = (k_ff == pm1_aw);
      ctl_in.live      = (FW'(age) < fill_ff);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_push) begin
               state_in = ST_RUN;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            if (k_ff == pm1_aw) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.result_value   = RESULT_BITS'(acc_sum);
               rsp_data_in.last_of_stream = last_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         plen_ff      <= PLEN_BITS'(1);
         ptr_ff       <= '0;
         fill_ff      <= '0;
         taps_ff      <= '0;
         tail_ff      <= '0;
         last_ff      <= 1'b0;
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         plen_ff      <= plen_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         taps_ff      <= taps_in;
         tail_ff      <= tail_in;
         last_ff      <= last_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   lcc_ram #(
      .DEPTH     (MAX_TAPS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_patch_ram (
      .clock   (clock),
      .wr_en   (patch_wr_en),
      .wr_addr (AW'(tap_idx)),
      .wr_data (req_data.sample_value),
      .rd_addr (k_ff),
      .rd_data (patch_rd)
   );

   lcc_ram #(
      .DEPTH     (MAX_TAPS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (ptr_next),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd)
   );

   lcc_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_ff),
      .patch_tap   (patch_rd),
      .hist_sample (hist_rd),
      .acc_sum     (acc_sum),
      .done        (mac_done)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_DRAIN)
      else $error("Accumulator finished outside the drain state.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_TAPS))
      else $error("History fill count exceeds the memory depth.");

   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> k_ff <= pm1_aw)
      else $error("Tap counter ran past the patch length.");

   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> $past(state_ff) == ST_RUN)
      else $error("Tap issued to the multiplier outside the run state.");
`endif

endmodule

[verif/tb_linear_convolution_correlation.sv]
// Self-checking testbench for the linear convolution and correlation block.
// Predicts every response in-house and checks it against the block under random idling.
// Depends on lcc_pkg and linear_convolution_correlation from the rtl folder.
module tb_linear_convolution_correlation;
   import lcc_pkg::*;

   localparam int MAX_TAPS       = 1024;
   localparam int TAIL_LIMIT     = 2047;
   localparam int RANDOM_ITEMS   = 440;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 100;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE0 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE1 = 2'd3;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
   localparam longint RESULT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint RESULT_MIN = -RESULT_MAX - 1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   lcc_req_type               req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   lcc_rsp_type               rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [PLEN_BITS-1:0]      csr_wdata;

   logic signed [SAMPLE_BITS-1:0] tap_mem  [0:MAX_TAPS-1];
   bit                            tap_written [0:MAX_TAPS-1];
   logic signed [SAMPLE_BITS-1:0] hist_mem [0:MAX_TAPS-1];
   int                            hist_ptr;
   int                            taps_loaded;
   int                            tail_steps;
   logic                          mode_reg;
   logic [PLEN_BITS-1:0]          plen_reg;

   lcc_rsp_type expected_filter_out[$];
   int          error_count;
   int          quiet_cycles;
   int          hold_off_cycles;
   bit          send_gaps;
   bit          stall_gaps;

   linear_convolution_correlation #(
      .MAX_TAPS(MAX_TAPS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string detail);
      if (error_count < MAX_REPORTS) begin
         $display("ERROR: %s", detail);
      end
      error_count++;
   endtask

   function automatic int active_taps();
      if (plen_reg == 0) begin
         return 1;
      end
      if (plen_reg > MAX_TAPS) begin
         return MAX_TAPS;
      end
      return int'(plen_reg);
   endfunction

   function automatic bit patch_ready();
      for (int k = 0; k < active_taps(); k++) begin
         if (!tap_written[k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic clear_history();
      for (int i = 0; i < MAX_TAPS; i++) begin
         hist_mem[i] = '0;
      end
      hist_ptr   = 0;
      tail_steps = 0;
   endtask

   task automatic reset_filter_model();
      for (int i = 0; i < MAX_TAPS; i++) begin
         tap_mem[i]     = '0;
         tap_written[i] = 1'b0;
      end
      clear_history();
      taps_loaded = 0;
      mode_reg    = 1'b0;
      plen_reg    = 11'd1;
   endtask

   task automatic predict_filter_output(input lcc_req_type req);
      int          p;
      int          age;
      int          idx;
      longint      acc;
      lcc_rsp_type rsp;
      p = active_taps();
      rsp.last_of_stream = 1'b0;
      if (req.operation == OP_LOAD) begin
         if (taps_loaded >= p) begin
            taps_loaded = 0;
         end
         tap_mem[taps_loaded % MAX_TAPS]     = req.sample_value;
         tap_written[taps_loaded % MAX_TAPS] = 1'b1;
         taps_loaded++;
         clear_history();
      end else if (req.operation == OP_SAMPLE || req.operation == OP_TAIL) begin
         hist_ptr = (hist_ptr + 1) % MAX_TAPS;
         if (req.operation == OP_SAMPLE) begin
            hist_mem[hist_ptr] = req.sample_value;
            tail_steps = 0;
         end else begin
            hist_mem[hist_ptr] = '0;
            if (tail_steps < TAIL_LIMIT) begin
               tail_steps++;
            end
            rsp.last_of_stream = (tail_steps == p - 1);
         end
         acc = 0;
         for (int k = 0; k < p; k++) begin
            age = mode_reg ? (p - 1 - k) : k;
            idx = (hist_ptr + MAX_TAPS - age) % MAX_TAPS;
            acc += longint'(tap_mem[k]) * longint'(hist_mem[idx]);
         end
         if (acc > RESULT_MAX) begin
            acc = RESULT_MAX;
         end
         if (acc < RESULT_MIN) begin
            acc = RESULT_MIN;
         end
         rsp.result_value = acc[RESULT_BITS-1:0];
         expected_filter_out = {expected_filter_out, rsp};
      end
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: begin
            return SAMPLE_MAX;
         end
         1: begin
            return SAMPLE_MIN;
         end
         2: begin
            return SAMPLE_BITS'($urandom_range(0, 15)) - 16'sd8;
         end
         default: begin
            return SAMPLE_BITS'($urandom);
         end
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op, input logic signed [SAMPLE_BITS-1:0] value);
      lcc_req_type req;
      logic [31:0] noise;
      req.operation    = op;
      req.sample_value = value;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         noise = $urandom;
         req_valid <= 1'b0;
         req_data  <= noise[$bits(lcc_req_type)-1:0];
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall);
      predict_filter_output(req);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [PLEN_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_MODE) begin
         mode_reg = data[0];
      end else if (index == CSR_PLEN) begin
         plen_reg = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_mode(input logic correlate);
      logic [PLEN_BITS-1:0] word;
      word    = PLEN_BITS'($urandom);
      word[0] = correlate;
      write_register(CSR_MODE, word);
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (expected_filter_out.size() != 0) @(negedge clock);
      repeat (active_taps() + 10) @(negedge clock);
   endtask

   task automatic test_directed();
      write_register(CSR_PLEN, 11'd3);
      set_mode(1'b0);
      send_request(OP_LOAD, SAMPLE_MAX);
      send_request(OP_LOAD, SAMPLE_MIN);
      send_request(OP_LOAD, 16'shFFFF);
      send_request(OP_SAMPLE, SAMPLE_MIN);
      send_request(OP_SAMPLE, SAMPLE_MIN);
      send_request(OP_SAMPLE, SAMPLE_MAX);
      send_request(OP_SAMPLE, 16'sd0);
      send_request(OP_SAMPLE, 16'sd1);
      send_request(OP_UNUSED, 16'sh5A5A);
      repeat (3) send_request(OP_TAIL, SAMPLE_MAX);
      wait_for_quiet();
      set_mode(1'b1);
      send_request(OP_SAMPLE, SAMPLE_MAX);
      send_request(OP_SAMPLE, SAMPLE_MIN);
      repeat (2) send_request(OP_TAIL, SAMPLE_MIN);
      // The patch is full, so this load restarts at the first tap and clears the history.
      send_request(OP_LOAD, 16'sd12345);
      send_request(OP_SAMPLE, 16'sd100);
      send_request(OP_TAIL, 16'sd0);
      wait_for_quiet();
   endtask

   task automatic test_patch_extremes();
      write_register(CSR_PLEN, 11'd0);
      send_request(OP_SAMPLE, SAMPLE_MAX);
      send_request(OP_LOAD, SAMPLE_MIN);
      send_request(OP_SAMPLE, SAMPLE_MIN);
      repeat (2) send_request(OP_TAIL, pick_sample());
      wait_for_quiet();
      write_register(CSR_SPARE0, PLEN_BITS'($urandom));
      write_register(CSR_SPARE1, PLEN_BITS'($urandom));
      set_mode(~mode_reg);
      send_request(OP_SAMPLE, pick_sample());
      send_request(OP_TAIL, pick_sample());
      wait_for_quiet();
   endtask

   task automatic test_random_streams();
      int sent;
      int p;
      int n;
      int r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            wait_for_quiet();
            r = $urandom_range(0, 19);
            if (r < 14) begin
               p = $urandom_range(1, 8);
            end else if (r < 19) begin
               p = $urandom_range(9, 48);
            end else begin
               p = $urandom_range(100, 160);
            end
            write_register(CSR_PLEN, PLEN_BITS'(p));
            set_mode(1'($urandom_range(0, 1)));
         end
         p = active_taps();
         n = p;
         if (patch_ready() && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, p + 2);
         end
         repeat (n) send_request(OP_LOAD, pick_sample());
         sent += n;
         n = $urandom_range(1, 10);
         repeat (n) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
               send_request(OP_UNUSED, pick_sample());
            end else if (r == 1) begin
               send_request(OP_LOAD, pick_sample());
               sent++;
            end
            send_request(OP_SAMPLE, pick_sample());
            sent++;
         end
         r = $urandom_range(0, 9);
         if (r == 0) begin
            n = $urandom_range(0, p - 1);
         end else if (r == 1) begin
            n = p + 1;
         end else begin
            n = p - 1;
         end
         repeat (n) send_request(OP_TAIL, pick_sample());
         sent += n;
      end
      wait_for_quiet();
   endtask

   task automatic test_output_backpressure();
      write_register(CSR_PLEN, 11'd4);
      set_mode(1'($urandom_range(0, 1)));
      repeat (4) send_request(OP_LOAD, pick_sample());
      hold_off_cycles = 300;
      repeat (40) send_request(OP_SAMPLE, pick_sample());
      repeat (3) send_request(OP_TAIL, pick_sample());
      wait_for_quiet();
   endtask

   task automatic test_full_rate();
      int p;
      send_gaps  = 1'b0;
      stall_gaps = 1'b0;
      p = $urandom_range(2, 6);
      write_register(CSR_PLEN, PLEN_BITS'(p));
      set_mode(1'($urandom_range(0, 1)));
      repeat (p) send_request(OP_LOAD, pick_sample());
      repeat (50) send_request(OP_SAMPLE, pick_sample());
      repeat (p - 1) send_request(OP_TAIL, pick_sample());
      wait_for_quiet();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (stall_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      lcc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_filter_out.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", rsp_data));
         end else begin
            want = expected_filter_out.pop_front();
            if (rsp_data.result_value !== want.result_value) begin
               report_mismatch($sformatf("result_value got %h expected %h",
                                         rsp_data.result_value, want.result_value));
            end
            if (rsp_data.last_of_stream !== want.last_of_stream) begin
               report_mismatch($sformatf("last_of_stream got %b expected %b",
                                         rsp_data.last_of_stream, want.last_of_stream));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      error_count     = 0;
      quiet_cycles    = 0;
      hold_off_cycles = 0;
      send_gaps       = 1'b1;
      stall_gaps      = 1'b1;
      reset_filter_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_patch_extremes();
      test_random_streams();
      test_output_backpressure();
      test_full_rate();
      if (expected_filter_out.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_filter_out.size()));
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/lcc_pkg.sv
rtl/lcc_ram.sv
rtl/lcc_mac.sv
rtl/linear_convolution_correlation.sv
verif/tb_linear_convolution_correlation.sv
